// File: sv/tqr_pkg.sv
`default_nettype none

package tqr_pkg;

  localparam int unsigned QueueDepth = 1024;
  localparam int unsigned BatchLimit = 64;
  localparam int unsigned GroupCount = 16;

  localparam int unsigned PtrW    = $clog2(QueueDepth);
  localparam int unsigned OccW    = 11;
  localparam int unsigned BatchW  = $clog2(BatchLimit + 1);
  localparam int unsigned BIdxW   = (BatchLimit > 1) ? $clog2(BatchLimit) : 1;
  localparam int unsigned GrpW    = 4;
  localparam int unsigned WordW   = 64;
  localparam int unsigned LimitW  = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(921);

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_URGENT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_THROTTLED = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_QUERY     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THROTTLE_ON    = 2'd0,
    CFG_THROTTLE_LIMIT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] handle;
    logic [WordW-1:0] argument;
    logic [GrpW-1:0]  group;
    logic [WordW-1:0] wait_tag;
    logic [WordW-1:0] arena_tag;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/tqr_ram.sv
`default_nettype none

module tqr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/task_ring_queue_with_group_counts_top.sv
// Push, urgent push, query and pop of an empty queue are answered from idle; the result word
// appears in the cycle after start is taken and busy_o stays low.
// A pop batch of n words (n = min(pending, 64)) makes a counting pass and then an emitting pass
// over the single read port of the entry memory, each with a read state and a use state per entry.
// Result words are shown for one cycle with out_valid_o and cannot be stalled.
// Reset clears the pointers and counters, turns throttling off and sets the threshold to 921.
`default_nettype none

module task_ring_queue_with_group_counts_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tqr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tqr_pkg::LimitW-1:0]  cfg_data_i,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [63:0]                 task_handle_i,
  input  wire logic [63:0]                 task_argument_i,
  input  wire logic [7:0]                  group_in_i,
  input  wire logic [63:0]                 wait_tag_in_i,
  input  wire logic [63:0]                 arena_tag_in_i,
  output logic                             out_valid_o,
  output logic [2:0]                       status_o,
  output logic [63:0]                      out_handle_o,
  output logic [63:0]                      out_argument_o,
  output logic [3:0]                       out_group_o,
  output logic [63:0]                      out_wait_tag_o,
  output logic [63:0]                      out_arena_tag_o,
  output logic [10:0]                      pending_count_o,
  output logic [63:0]                      total_done_o,
  output logic [63:0]                      group_done_o,
  output logic                             last_o
);

  localparam int unsigned PtrW = tqr_pkg::PtrW;
  localparam int unsigned OccW = tqr_pkg::OccW;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN_RD  = 5'b00010,
    S_SCAN_ACC = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } state_e;

  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] a,
                                              input logic [PtrW:0]   b);
    logic [PtrW:0] sum;
    sum = {1'b0, a} + b;
    if (sum >= (PtrW+1)'(tqr_pkg::QueueDepth)) begin
      sum = sum - (PtrW+1)'(tqr_pkg::QueueDepth);
    end
    return sum[PtrW-1:0];
  endfunction

  state_e                        state_q, state_d;
  logic [PtrW-1:0]               head_q, head_d;
  logic [OccW-1:0]               occ_q, occ_d;
  logic [PtrW-1:0]               base_q, base_d;
  logic [tqr_pkg::BatchW-1:0]    batch_q, batch_d;
  logic [tqr_pkg::BIdxW-1:0]     idx_q, idx_d;
  logic [63:0]                   total_q, total_d;
  logic [63:0]                   grp_cnt_q [tqr_pkg::GroupCount];
  logic                          thr_on_q;
  logic [tqr_pkg::LimitW-1:0]    thr_lim_q;

  logic                          accept;
  logic                          last_idx;
  logic [tqr_pkg::BatchW-1:0]    batch_n;
  logic [tqr_pkg::GrpW-1:0]      gsel;
  logic [63:0]                   gcnt_rd;
  logic                          cnt_inc;
  logic                          grp_ok;
  logic [tqr_pkg::GrpW-1:0]      push_grp;

  logic                          ram_we, ram_re;
  logic [PtrW-1:0]               ram_waddr, ram_raddr;
  tqr_pkg::entry_t               ram_wdata, ram_rdata;

  logic                          out_load;
  logic [2:0]                    status_d;
  tqr_pkg::entry_t               out_entry_d;
  logic [63:0]                   group_done_d;
  logic                          last_d;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign last_idx = (tqr_pkg::BatchW'(idx_q) + tqr_pkg::BatchW'(1)) == batch_q;
  assign batch_n  = (occ_q >= OccW'(tqr_pkg::BatchLimit)) ?
                    tqr_pkg::BatchW'(tqr_pkg::BatchLimit) : tqr_pkg::BatchW'(occ_q);
  assign grp_ok   = (group_in_i < 8'(tqr_pkg::GroupCount));
  assign push_grp = grp_ok ? group_in_i[tqr_pkg::GrpW-1:0] : '0;
  assign gsel     = (state_q == S_IDLE) ? group_in_i[tqr_pkg::GrpW-1:0] : ram_rdata.group;
  assign gcnt_rd  = grp_cnt_q[gsel];
  assign cnt_inc  = (state_q == S_SCAN_ACC) && (ram_rdata.handle != '0) &&
                    (32'(ram_rdata.group) < tqr_pkg::GroupCount);
  assign ram_raddr = ptr_add(base_q, (PtrW+1)'(idx_q));
  assign ram_re    = (state_q == S_SCAN_RD) || (state_q == S_EMIT_RD);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    occ_d        = occ_q;
    base_d       = base_q;
    batch_d      = batch_q;
    idx_d        = idx_q;
    total_d      = total_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_add(head_q, (PtrW+1)'(occ_q));
    ram_wdata    = '{handle: task_handle_i, argument: task_argument_i, group: push_grp,
                     wait_tag: wait_tag_in_i, arena_tag: arena_tag_in_i};
    out_load     = 1'b0;
    status_d     = tqr_pkg::ST_ACCEPTED;
    out_entry_d  = '0;
    group_done_d = '0;
    last_d       = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (tqr_pkg::mode_e'(mode_i))
            tqr_pkg::MODE_PUSH: begin
              out_load = 1'b1;
              if (occ_q >= OccW'(tqr_pkg::QueueDepth)) begin
                status_d = tqr_pkg::ST_FULL;
              end else if (thr_on_q && (occ_q > OccW'(thr_lim_q))) begin
                status_d = tqr_pkg::ST_THROTTLED;
              end else begin
                ram_we = 1'b1;
                occ_d  = occ_q + OccW'(1);
              end
            end
            tqr_pkg::MODE_URGENT: begin
              out_load = 1'b1;
              if (occ_q >= OccW'(tqr_pkg::QueueDepth)) begin
                status_d = tqr_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                head_d    = (head_q == '0) ? PtrW'(tqr_pkg::QueueDepth - 1) : head_q - PtrW'(1);
                ram_waddr = head_d;
                ram_wdata = '{handle: task_handle_i, argument: task_argument_i, group: '0,
                              wait_tag: '0, arena_tag: '0};
                occ_d     = occ_q + OccW'(1);
              end
            end
            tqr_pkg::MODE_POP: begin
              if (occ_q == '0) begin
                out_load = 1'b1;
                status_d = tqr_pkg::ST_EMPTY;
              end else begin
                base_d  = head_q;
                batch_d = batch_n;
                head_d  = ptr_add(head_q, (PtrW+1)'(batch_n));
                occ_d   = occ_q - OccW'(batch_n);
                idx_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            tqr_pkg::MODE_QUERY: begin
              out_load     = 1'b1;
              status_d     = tqr_pkg::ST_QUERY;
              group_done_d = grp_ok ? gcnt_rd : '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_ACC;
      end
      S_SCAN_ACC: begin
        if (ram_rdata.handle != '0) begin
          total_d = total_q + 64'd1;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end else begin
          idx_d   = idx_q + tqr_pkg::BIdxW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        out_load    = 1'b1;
        status_d    = tqr_pkg::ST_POPPED;
        out_entry_d = ram_rdata;
        last_d      = last_idx;
        if (last_idx) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + tqr_pkg::BIdxW'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  tqr_ram #(
    .Width($bits(tqr_pkg::entry_t)),
    .Depth(tqr_pkg::QueueDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      base_q      <= '0;
      batch_q     <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      grp_cnt_q   <= '{default: '0};
      thr_on_q    <= 1'b0;
      thr_lim_q   <= tqr_pkg::LimitReset;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      base_q      <= base_d;
      batch_q     <= batch_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      out_valid_o <= out_load;
      if (cnt_inc) begin
        grp_cnt_q[gsel] <= gcnt_rd + 64'd1;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == tqr_pkg::CFG_THROTTLE_ON) begin
          thr_on_q <= cfg_data_i[0];
        end else if ((cfg_index_i == tqr_pkg::CFG_THROTTLE_LIMIT) && (cfg_data_i != '0)) begin
          thr_lim_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o        <= status_d;
      out_handle_o    <= out_entry_d.handle;
      out_argument_o  <= out_entry_d.argument;
      out_group_o     <= out_entry_d.group;
      out_wait_tag_o  <= out_entry_d.wait_tag;
      out_arena_tag_o <= out_entry_d.arena_tag;
      pending_count_o <= occ_d;
      total_done_o    <= total_d;
      group_done_o    <= group_done_d;
      last_o          <= last_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/tqr_checker.sv
`default_nettype none

module tqr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [1:0]  mode_i,
  input wire logic        out_valid_o,
  input wire logic [2:0]  status_o,
  input wire logic [10:0] pending_count_o,
  input wire logic        last_o
);

  // A command other than a pop always answers with one final word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (mode_i != tqr_pkg::MODE_POP) |=> out_valid_o && last_o && !busy_o)
    else $error("single-word command did not answer in the next cycle");

  // The final word of a batch comes with the block already free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !busy_o)
    else $error("busy still high on final word");

  // A word that is not the last one belongs to a running batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy_o && (status_o == tqr_pkg::ST_POPPED))
    else $error("non-final word outside a batch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tqr_pkg::ST_EMPTY) |-> (pending_count_o == '0))
    else $error("empty answer with entries pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tqr_pkg::ST_ACCEPTED) |-> (pending_count_o != '0))
    else $error("accepted push left the queue empty");

endmodule

bind task_ring_queue_with_group_counts_top tqr_checker u_tqr_checker (.*);

`default_nettype wire
